[rtl/core/lffm_pkg.sv]
// Package for the lateral friction force map: word types, register codes,
// fixed-point constants and the back-end sequencer states. No dependencies.
package lffm_pkg;

    typedef struct packed {
        logic signed [31:0] height;
        logic               last_in_row;
    } item_t;

    typedef struct packed {
        logic signed [39:0] forward_force;
        logic signed [39:0] reverse_force;
        logic               stuck;
        logic               row_end;
    } result_t;

    typedef struct packed {
        logic [20:0] friction_coefficient;
        logic [19:0] normal_load;
        logic [19:0] adhesion_force;
        logic [30:0] pixel_spacing;
    } cfg_t;

    // One slope to be evaluated: height difference, span of two spacings or one.
    typedef struct packed {
        logic signed [32:0] diff;
        logic               span2;
        logic               row_end;
    } job_t;

    typedef enum logic [1:0] {
        CFG_FRICTION = 2'd0,
        CFG_LOAD     = 2'd1,
        CFG_ADHESION = 2'd2,
        CFG_SPACING  = 2'd3
    } cfg_index_t;

    typedef enum logic [4:0] {
        B_IDLE,
        B_T_START,
        B_T_WAIT,
        B_MUL_TT,
        B_R_START,
        B_R_WAIT,
        B_MUL_MA,
        B_MUL_MAH,
        B_MUL_MAL,
        B_MUL_ML,
        B_MUL_LT,
        B_MUL_MT,
        B_P_START,
        B_P_WAIT,
        B_Q_START,
        B_Q_WAIT,
        B_OUT
    } back_state_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 31;

    localparam logic [20:0] FRICTION_RESET = 21'd65536;
    localparam logic [19:0] LOAD_RESET     = 20'd1000;
    localparam logic [19:0] ADHESION_RESET = 20'd1000;
    localparam logic [30:0] SPACING_RESET  = 31'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_NUM_W  = 60;
    localparam int DIV_DEN_W  = 40;
    localparam int DIV_STEPS  = DIV_NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int SQRT_W     = 64;
    localparam int SQRT_STEPS = SQRT_W / 2;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
    localparam logic [SQRT_W-1:0] SQRT_TOP = 64'h4000_0000_0000_0000;

    localparam logic [30:0]        T_MAX     = 31'h7FFF_FFFF;
    localparam logic [39:0]        ONE_Q16   = 40'd65536;
    localparam logic signed [39:0] FORCE_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] FORCE_MIN = 40'sh80_0000_0000;

endpackage

[rtl/core/lateral_friction_force_map.sv]
// Top level of the lateral friction force map: configuration registers,
// front end, job queue and back end. Uses lffm_pkg, lffm_front, lffm_queue, lffm_back.
//
//   channel   signals                               word type
//   item      item_valid, item_stall, item          lffm_pkg::item_t
//   result    result_valid, result_stall, result    lffm_pkg::result_t
//   config    cfg_write, cfg_index, cfg_data        31-bit data, 2-bit index
//
// Each result uses two or three divisions on the shared bit-serial divider (two when
// the job is stuck) and a square root in the back end, plus the multiply steps.
// The front end takes a new word once its jobs are in the two-entry queue.
// Reset clears the held samples, the queue and the result valid flag and loads
// the register defaults. A stalled result holds its word while the back end waits.
module lateral_friction_force_map (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  lffm_pkg::item_t                    item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output lffm_pkg::result_t                  result,
    input  logic                               cfg_write,
    input  logic [lffm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lffm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    lffm_pkg::cfg_t  cfg_reg;
    logic            push, full, pop, empty;
    lffm_pkg::job_t  push_job, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.friction_coefficient <= lffm_pkg::FRICTION_RESET;
            cfg_reg.normal_load          <= lffm_pkg::LOAD_RESET;
            cfg_reg.adhesion_force       <= lffm_pkg::ADHESION_RESET;
            cfg_reg.pixel_spacing        <= lffm_pkg::SPACING_RESET;
        end
        else if (cfg_write)
        begin
            unique case (lffm_pkg::cfg_index_t'(cfg_index))
                lffm_pkg::CFG_FRICTION: cfg_reg.friction_coefficient <= cfg_data[20:0];
                lffm_pkg::CFG_LOAD:     cfg_reg.normal_load          <= cfg_data[19:0];
                lffm_pkg::CFG_ADHESION: cfg_reg.adhesion_force       <= cfg_data[19:0];
                lffm_pkg::CFG_SPACING:  cfg_reg.pixel_spacing        <= cfg_data[30:0];
                default:
                begin
                end
            endcase
        end
    end

    lffm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .push_job   (push_job),
        .full       (full)
    );

    lffm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    lffm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .job_valid    (!empty),
        .pop          (pop),
        .head         (head),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[rtl/core/lffm_queue.sv]
// Two-entry job queue between the front and back ends of the force map.
// Depends on lffm_pkg for the job type and depth.
module lffm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lffm_pkg::job_t    push_job,
    output logic              full,
    input  logic              pop,
    output lffm_pkg::job_t    head,
    output logic              empty
);

    lffm_pkg::job_t                         entry_reg [lffm_pkg::QUEUE_DEPTH];
    logic [lffm_pkg::QUEUE_PTR_W-1:0]       wr_ptr_reg;
    logic [lffm_pkg::QUEUE_PTR_W-1:0]       rd_ptr_reg;
    logic [lffm_pkg::QUEUE_CNT_W-1:0]       count_reg;
    logic                                   do_push;
    logic                                   do_pop;

    assign full    = count_reg == lffm_pkg::QUEUE_CNT_W'(lffm_pkg::QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/core/lffm_front.sv]
// Front end of the force map: takes height words, keeps the last two samples
// of the row and turns each word into zero, one or two slope jobs. Uses lffm_pkg.
module lffm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  lffm_pkg::item_t   item,
    output logic              push,
    output lffm_pkg::job_t    push_job,
    input  logic              full
);

    logic [31:0]         older_reg, older_next;
    logic [31:0]         newer_reg, newer_next;
    logic [1:0]          count_reg, count_next;
    logic                v0_reg, v1_reg;
    lffm_pkg::job_t      job0_reg, job1_reg;
    logic                gen0_valid, gen1_valid;
    lffm_pkg::job_t      gen0, gen1;
    logic                accept;
    logic signed [32:0]  hv, nv, ov;

    assign item_stall = v0_reg || v1_reg;
    assign accept     = item_valid && !item_stall;
    assign push       = v0_reg && !full;
    assign push_job   = job0_reg;

    assign hv = 33'(item.height);
    assign nv = 33'($signed(newer_reg));
    assign ov = 33'($signed(older_reg));

    always_comb
    begin
        older_next = older_reg;
        newer_next = newer_reg;
        count_next = count_reg;
        gen0_valid = 1'b0;
        gen1_valid = 1'b0;
        gen0       = '0;
        gen1       = '0;
        if (count_reg == 2'd0)
        begin
            if (item.last_in_row)
            begin
                gen0_valid   = 1'b1;
                gen0.row_end = 1'b1;
            end
            else
            begin
                newer_next = item.height;
                count_next = 2'd1;
            end
        end
        else
        begin
            gen0_valid = 1'b1;
            if (count_reg == 2'd1)
            begin
                gen0.diff = hv - nv;
            end
            else
            begin
                gen0.diff  = hv - ov;
                gen0.span2 = 1'b1;
            end
            if (item.last_in_row)
            begin
                gen1_valid   = 1'b1;
                gen1.diff    = hv - nv;
                gen1.row_end = 1'b1;
                count_next   = 2'd0;
            end
            else
            begin
                older_next = newer_reg;
                newer_next = item.height;
                count_next = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg <= '0;
            newer_reg <= '0;
            count_reg <= '0;
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
        end
        else if (accept)
        begin
            older_reg <= older_next;
            newer_reg <= newer_next;
            count_reg <= count_next;
            v0_reg    <= gen0_valid;
            v1_reg    <= gen1_valid;
        end
        else if (push)
        begin
            v0_reg <= v1_reg;
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job0_reg <= gen0;
            job1_reg <= gen1;
        end
        else if (push)
        begin
            job0_reg <= job1_reg;
        end
    end

endmodule

[rtl/core/lffm_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on lffm_pkg for its widths.
module lffm_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [lffm_pkg::DIV_NUM_W-1:0]    num,
    input  logic [lffm_pkg::DIV_DEN_W-1:0]    den,
    output logic                              done,
    output logic [lffm_pkg::DIV_NUM_W-1:0]    quot
);

    logic [lffm_pkg::DIV_NUM_W-1:0]  acc_reg;
    logic [lffm_pkg::DIV_DEN_W-1:0]  rem_reg;
    logic [lffm_pkg::DIV_DEN_W-1:0]  den_reg;
    logic [lffm_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic [lffm_pkg::DIV_DEN_W:0]    rem_shift;
    logic [lffm_pkg::DIV_DEN_W:0]    rem_sub;
    logic                            fits;

    assign rem_shift = {rem_reg, acc_reg[lffm_pkg::DIV_NUM_W-1]};
    assign rem_sub   = rem_shift - {1'b0, den_reg};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign done      = done_reg;
    assign quot      = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == lffm_pkg::DIV_CNT_W'(lffm_pkg::DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[lffm_pkg::DIV_DEN_W-1:0]
                            : rem_shift[lffm_pkg::DIV_DEN_W-1:0];
            acc_reg <= {acc_reg[lffm_pkg::DIV_NUM_W-2:0], fits};
        end
    end

endmodule

[rtl/core/lffm_sqrt.sv]
// Integer square root, two radicand bits per cycle, for r = sqrt(1 + t*t).
// Depends on lffm_pkg for its widths.
module lffm_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lffm_pkg::SQRT_W-1:0]   radicand,
    output logic                          done,
    output logic [31:0]                   root
);

    logic [lffm_pkg::SQRT_W-1:0]      op_reg;
    logic [lffm_pkg::SQRT_W-1:0]      res_reg;
    logic [lffm_pkg::SQRT_W-1:0]      bit_reg;
    logic [lffm_pkg::SQRT_CNT_W-1:0]  cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic [lffm_pkg::SQRT_W-1:0]      trial;
    logic                             ge;

    assign trial = res_reg + bit_reg;
    assign ge    = op_reg >= trial;
    assign done  = done_reg;
    assign root  = res_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == lffm_pkg::SQRT_CNT_W'(lffm_pkg::SQRT_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg  <= radicand;
            res_reg <= '0;
            bit_reg <= lffm_pkg::SQRT_TOP;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                op_reg  <= op_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

[rtl/core/lffm_back.sv]
// Back end of the force map: evaluates one slope job at a time with a shared
// divider and root unit and holds the result word. Uses lffm_pkg, lffm_div, lffm_sqrt.
module lffm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  lffm_pkg::cfg_t    cfg,
    input  logic              job_valid,
    output logic              pop,
    input  lffm_pkg::job_t    head,
    output logic              result_valid,
    input  logic              result_stall,
    output lffm_pkg::result_t result
);

    lffm_pkg::back_state_t  state_reg, state_next;
    lffm_pkg::job_t         job_reg;
    logic [30:0]            t_reg;
    logic [61:0]            tt_reg;
    logic [31:0]            r_reg;
    logic [40:0]            ma_reg;
    logic [56:0]            p1_reg;
    logic [56:0]            p2_reg;
    logic [40:0]            ml_reg;
    logic [57:0]            base_reg;
    logic [50:0]            lt_reg;
    logic [35:0]            mt_reg;
    logic signed [39:0]     pf_reg;
    logic signed [39:0]     qf_reg;
    logic                   stuck_reg;
    lffm_pkg::result_t      res_reg;
    logic                   res_valid_reg;

    logic                   div_start, sqrt_start, out_load;
    logic                   div_done, sqrt_done;
    logic [59:0]            div_num, quot;
    logic [39:0]            div_den;
    logic [31:0]            root;
    logic [32:0]            mag;
    logic [30:0]            sp;
    logic [31:0]            den_t;
    logic [51:0]            mt_full;
    logic signed [59:0]     q_signed;
    logic                   q_neg;
    logic [59:0]            q_mag;
    logic                   stuck_now;
    logic                   out_free;

    function automatic logic signed [39:0] sat_pos(input logic [59:0] v);
        logic signed [39:0] r;
        if (v > 60'(lffm_pkg::FORCE_MAX))
        begin
            r = lffm_pkg::FORCE_MAX;
        end
        else
        begin
            r = v[39:0];
        end
        return r;
    endfunction

    function automatic logic signed [39:0] sat_neg(input logic [59:0] v);
        logic signed [39:0] r;
        if (v > 60'h80_0000_0000)
        begin
            r = lffm_pkg::FORCE_MIN;
        end
        else
        begin
            r = -v[39:0];
        end
        return r;
    endfunction

    lffm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (quot)
    );

    lffm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({2'b00, tt_reg} + 64'h1_0000_0000),
        .done     (sqrt_done),
        .root     (root)
    );

    assign mag       = job_reg.diff[32] ? (~job_reg.diff + 33'd1) : job_reg.diff;
    assign sp        = (cfg.pixel_spacing == '0) ? 31'd1 : cfg.pixel_spacing;
    assign den_t     = job_reg.span2 ? {sp, 1'b0} : {1'b0, sp};
    assign mt_full   = 52'(cfg.friction_coefficient) * 52'(t_reg);
    assign q_signed  = $signed({2'b00, base_reg}) - $signed({9'd0, lt_reg});
    assign q_neg     = q_signed[59];
    assign q_mag     = q_neg ? 60'(-q_signed) : 60'(q_signed);
    assign stuck_now = mt_reg[35:16] != '0;
    assign out_free  = !res_valid_reg || !result_stall;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        unique case (state_reg)
            lffm_pkg::B_T_START:
            begin
                div_num = 60'({mag, 16'd0});
                div_den = 40'(den_t);
            end
            lffm_pkg::B_P_START:
            begin
                div_num = 60'(base_reg) + 60'(lt_reg);
                div_den = lffm_pkg::ONE_Q16 - 40'(mt_reg);
            end
            default:
            begin
                div_num = q_mag;
                div_den = 40'(mt_reg) + lffm_pkg::ONE_Q16;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lffm_pkg::B_IDLE:    if (job_valid) state_next = lffm_pkg::B_T_START;
            lffm_pkg::B_T_START: state_next = lffm_pkg::B_T_WAIT;
            lffm_pkg::B_T_WAIT:  if (div_done) state_next = lffm_pkg::B_MUL_TT;
            lffm_pkg::B_MUL_TT:  state_next = lffm_pkg::B_R_START;
            lffm_pkg::B_R_START: state_next = lffm_pkg::B_R_WAIT;
            lffm_pkg::B_R_WAIT:  if (sqrt_done) state_next = lffm_pkg::B_MUL_MA;
            lffm_pkg::B_MUL_MA:  state_next = lffm_pkg::B_MUL_MAH;
            lffm_pkg::B_MUL_MAH: state_next = lffm_pkg::B_MUL_MAL;
            lffm_pkg::B_MUL_MAL: state_next = lffm_pkg::B_MUL_ML;
            lffm_pkg::B_MUL_ML:  state_next = lffm_pkg::B_MUL_LT;
            lffm_pkg::B_MUL_LT:  state_next = lffm_pkg::B_MUL_MT;
            lffm_pkg::B_MUL_MT:  state_next = lffm_pkg::B_P_START;
            lffm_pkg::B_P_START:
                state_next = stuck_now ? lffm_pkg::B_Q_START : lffm_pkg::B_P_WAIT;
            lffm_pkg::B_P_WAIT:  if (div_done) state_next = lffm_pkg::B_Q_START;
            lffm_pkg::B_Q_START: state_next = lffm_pkg::B_Q_WAIT;
            lffm_pkg::B_Q_WAIT:  if (div_done) state_next = lffm_pkg::B_OUT;
            lffm_pkg::B_OUT:     if (out_free) state_next = lffm_pkg::B_IDLE;
            default:             state_next = lffm_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        pop        = (state_reg == lffm_pkg::B_IDLE) && job_valid;
        div_start  = (state_reg == lffm_pkg::B_T_START)
                  || ((state_reg == lffm_pkg::B_P_START) && !stuck_now)
                  || (state_reg == lffm_pkg::B_Q_START);
        sqrt_start = state_reg == lffm_pkg::B_R_START;
        out_load   = (state_reg == lffm_pkg::B_OUT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lffm_pkg::B_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            lffm_pkg::B_IDLE:
                if (job_valid) job_reg <= head;
            lffm_pkg::B_T_WAIT:
                if (div_done) t_reg <= (quot > 60'(lffm_pkg::T_MAX)) ? lffm_pkg::T_MAX
                                                                      : quot[30:0];
            lffm_pkg::B_MUL_TT:
                tt_reg <= 62'(t_reg) * 62'(t_reg);
            lffm_pkg::B_R_WAIT:
                if (sqrt_done) r_reg <= root;
            lffm_pkg::B_MUL_MA:
                ma_reg <= 41'(cfg.friction_coefficient) * 41'(cfg.adhesion_force);
            lffm_pkg::B_MUL_MAH:
                p1_reg <= 57'(ma_reg) * 57'(r_reg[31:16]);
            lffm_pkg::B_MUL_MAL:
                p2_reg <= 57'(ma_reg) * 57'(r_reg[15:0]);
            lffm_pkg::B_MUL_ML:
                ml_reg <= 41'(cfg.friction_coefficient) * 41'(cfg.normal_load);
            lffm_pkg::B_MUL_LT:
            begin
                lt_reg   <= 51'(cfg.normal_load) * 51'(t_reg);
                base_reg <= 58'(ml_reg) + 58'(p1_reg) + 58'(p2_reg[56:16]);
            end
            lffm_pkg::B_MUL_MT:
                mt_reg <= mt_full[51:16];
            lffm_pkg::B_P_START:
            begin
                stuck_reg <= stuck_now;
                if (stuck_now) pf_reg <= lffm_pkg::FORCE_MAX;
            end
            lffm_pkg::B_P_WAIT:
                if (div_done) pf_reg <= sat_pos(quot);
            lffm_pkg::B_Q_WAIT:
                if (div_done) qf_reg <= q_neg ? sat_neg(quot) : sat_pos(quot);
            lffm_pkg::B_OUT:
                if (out_free)
                begin
                    res_reg.forward_force <= job_reg.diff[32] ? qf_reg : pf_reg;
                    res_reg.reverse_force <= job_reg.diff[32] ? pf_reg : qf_reg;
                    res_reg.stuck         <= stuck_reg;
                    res_reg.row_end       <= job_reg.row_end;
                end
            default:
            begin
            end
        endcase
    end

endmodule
